// ===== src/wald_pkg.sv =====
package wald_pkg;

  localparam int WINDOW   = 50;
  localparam int CHANNELS = 3;
  localparam int DEPTH    = WINDOW * CHANNELS;

  localparam int SAMPLE_W = 12;
  localparam int THR_W    = 12;
  localparam int RUN_W    = 8;
  localparam int CNT_W    = 8;
  localparam int CHOUT_W  = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam int SUM_W  = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(3500);
  localparam logic [RUN_W-1:0] RUN_RESET = RUN_W'(30);
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RUN_LENGTH      = CFG_IDX_W'(1);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_WORK
  } wald_state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } wald_cmd_t;

  typedef struct packed {
    logic out_free;
  } wald_stat_t;

endpackage

// ===== src/windowed_average_level_detector_core.sv =====
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    sample[11:0]
// out       output     out_valid/out_ready  channel[1:0], detected
// cfg       input      cfg_valid/cfg_ready  cfg_index[0], cfg_data[11:0]
//
// each sample request is captured in the idle state, which reads the window store,
// then committed from the work state: sum, count and store update and the output register loads
// a stalled output holds the commit until the output register frees
// a detection clears the channel window through per-entry valid bits within the commit
// synchronous reset clears valid bits, sums, counters, output valid and control state at once, no clearing pass
// cfg requests are taken every cycle and must arrive only while idle
module windowed_average_level_detector_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [wald_pkg::SAMPLE_W-1:0]        sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [wald_pkg::CHOUT_W-1:0]         channel,
  output logic                                 detected,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wald_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wald_pkg::CFG_DATA_W-1:0]      cfg_data
);

  wald_pkg::wald_cmd_t  cmd;
  wald_pkg::wald_stat_t stat;

  // register writes never stall
  assign cfg_ready = 1'b1;

  // sequencing of each sample request
  wald_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // window store, running sums, counters and output register
  wald_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .channel   (channel),
    .detected  (detected)
  );

  // capture and commit belong to different cycles
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.capture && cmd.commit))
    else $error("capture and commit in the same cycle");

  // no new request while one is in flight
  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> !in_ready)
    else $error("input accepted while a request is in flight");

  // a commit always leaves a result in the output register
  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit without a result");

  // never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");

endmodule

// ===== src/wald_ctrl.sv =====
module wald_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  wald_pkg::wald_stat_t stat,
  output logic                in_ready,
  output wald_pkg::wald_cmd_t cmd
);

  wald_pkg::wald_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wald_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      wald_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = wald_pkg::ST_WORK;
        end
      end
      wald_pkg::ST_WORK: begin
        // hold until the output register can take the result
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = wald_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wald_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/wald_datapath.sv =====
module wald_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  wald_pkg::wald_cmd_t                  cmd,
  output wald_pkg::wald_stat_t                 stat,
  input  logic                                 cfg_valid,
  input  logic [wald_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wald_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [wald_pkg::SAMPLE_W-1:0]        sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [wald_pkg::CHOUT_W-1:0]         channel,
  output logic                                 detected
);

  localparam int SUM_W  = wald_pkg::SUM_W;
  localparam int ADDR_W = wald_pkg::ADDR_W;
  localparam int POS_W  = wald_pkg::POS_W;
  localparam int CH_W   = wald_pkg::CH_W;
  localparam int CNT_W  = wald_pkg::CNT_W;

  // configuration, threshold kept pre-scaled by the window length
  logic [wald_pkg::RUN_W-1:0] run_length;
  logic [SUM_W-1:0]           thr_scaled;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_length <= wald_pkg::RUN_RESET;
      thr_scaled <= SUM_W'(int'(wald_pkg::THR_RESET) * wald_pkg::WINDOW);
    end else if (cfg_valid) begin
      case (cfg_index)
        wald_pkg::REG_LEVEL_THRESHOLD: begin
          thr_scaled <= SUM_W'(int'(cfg_data[wald_pkg::THR_W-1:0]) * wald_pkg::WINDOW);
        end
        wald_pkg::REG_RUN_LENGTH: begin
          run_length <= cfg_data[wald_pkg::RUN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // per-channel state
  logic [SUM_W-1:0] sum [wald_pkg::CHANNELS];
  logic [POS_W-1:0] pos [wald_pkg::CHANNELS];
  logic [CNT_W-1:0] cnt [wald_pkg::CHANNELS];
  logic [CH_W-1:0]  turn;

  // window store and its valid bits
  logic [wald_pkg::SAMPLE_W-1:0] mem [wald_pkg::DEPTH];
  logic [wald_pkg::DEPTH-1:0]    vld;

  // capture stage
  logic [wald_pkg::SAMPLE_W-1:0] s_q;
  logic [CH_W-1:0]               ch_q;
  logic [ADDR_W-1:0]             slot_q;
  logic                          hit_q;
  logic [wald_pkg::SAMPLE_W-1:0] rdata_q;

  logic [ADDR_W-1:0] slot_a;
  assign slot_a = ADDR_W'(int'(turn) * wald_pkg::WINDOW) + ADDR_W'(pos[turn]);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      s_q    <= sample;
      ch_q   <= turn;
      slot_q <= slot_a;
      hit_q  <= vld[slot_a];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rdata_q <= mem[slot_a];
    end
    if (cmd.commit) begin
      mem[slot_q] <= s_q;
    end
  end

  // commit stage arithmetic
  logic [wald_pkg::SAMPLE_W-1:0] old_s;
  logic [SUM_W-1:0]              sum_new;
  logic                          above;
  logic [CNT_W-1:0]              cnt_new;
  logic                          det;
  logic [POS_W-1:0]              pos_inc;

  always_comb begin
    old_s   = hit_q ? rdata_q : '0;
    sum_new = sum[ch_q] - SUM_W'(old_s) + SUM_W'(s_q);
    above   = sum_new > thr_scaled;
    if (!above) begin
      cnt_new = '0;
    end else if (cnt[ch_q] == wald_pkg::CNT_MAX) begin
      cnt_new = cnt[ch_q];
    end else begin
      cnt_new = cnt[ch_q] + CNT_W'(1);
    end
    det     = cnt_new > CNT_W'(run_length);
    pos_inc = (pos[ch_q] == POS_W'(wald_pkg::WINDOW - 1)) ? '0 : pos[ch_q] + POS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < wald_pkg::CHANNELS; c++) begin
        sum[c] <= '0;
        pos[c] <= '0;
        cnt[c] <= '0;
      end
      turn <= '0;
    end else if (cmd.commit) begin
      if (det) begin
        sum[ch_q] <= '0;
        pos[ch_q] <= '0;
        cnt[ch_q] <= '0;
      end else begin
        sum[ch_q] <= sum_new;
        pos[ch_q] <= pos_inc;
        cnt[ch_q] <= cnt_new;
      end
      turn <= (ch_q == CH_W'(wald_pkg::CHANNELS - 1)) ? '0 : ch_q + CH_W'(1);
    end
  end

  // a detection drops the whole window of that channel at once
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.commit) begin
      if (det) begin
        for (int e = 0; e < wald_pkg::DEPTH; e++) begin
          if ((e / wald_pkg::WINDOW) == int'(ch_q)) begin
            vld[e] <= 1'b0;
          end
        end
      end else begin
        vld[slot_q] <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      channel  <= wald_pkg::CHOUT_W'(ch_q);
      detected <= det;
    end
  end

  assign stat.out_free = !out_valid || out_ready;

endmodule

// ===== bench/windowed_average_level_detector_core_tb.sv =====
module windowed_average_level_detector_core_tb;

  // one expected result: channel tag and detection flag
  typedef struct packed {
    logic [wald_pkg::CHOUT_W-1:0] ch;
    logic                         hit;
  } detection_t;

  // per-channel window tracker, predicts the flag for every accepted sample
  class level_tracker;
    logic [wald_pkg::SAMPLE_W-1:0] window_mem   [wald_pkg::DEPTH];
    logic [wald_pkg::SUM_W-1:0]    window_total [wald_pkg::CHANNELS];
    logic [wald_pkg::POS_W-1:0]    write_pos    [wald_pkg::CHANNELS];
    logic [wald_pkg::CNT_W-1:0]    above_run    [wald_pkg::CHANNELS];
    logic [wald_pkg::CH_W-1:0]     turn;
    logic [wald_pkg::THR_W-1:0]    threshold;
    logic [wald_pkg::RUN_W-1:0]    run_limit;
    detection_t                    expected_q   [$];
    int                            results_seen;
    int                            error_count;

    function new();
      for (int c = 0; c < wald_pkg::CHANNELS; c++) clear_channel(c);
      turn         = '0;
      threshold    = wald_pkg::THR_RESET;
      run_limit    = wald_pkg::RUN_RESET;
      results_seen = 0;
      error_count  = 0;
    endfunction

    function void clear_channel(int c);
      for (int i = 0; i < wald_pkg::WINDOW; i++) window_mem[c * wald_pkg::WINDOW + i] = '0;
      window_total[c] = '0;
      write_pos[c]    = '0;
      above_run[c]    = '0;
    endfunction

    function void set_register(logic [wald_pkg::CFG_IDX_W-1:0] idx,
                               logic [wald_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        wald_pkg::REG_LEVEL_THRESHOLD: threshold = data[wald_pkg::THR_W-1:0];
        wald_pkg::REG_RUN_LENGTH:      run_limit = data[wald_pkg::RUN_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_sample(logic [wald_pkg::SAMPLE_W-1:0] s);
      int          slot;
      int unsigned floor_level;
      detection_t  res;
      slot = int'(turn) * wald_pkg::WINDOW + int'(write_pos[turn]);
      window_total[turn] = window_total[turn] - window_mem[slot] + s;
      window_mem[slot]   = s;
      write_pos[turn]    = (write_pos[turn] == wald_pkg::POS_W'(wald_pkg::WINDOW - 1)) ? '0 :
                           write_pos[turn] + 1'b1;
      floor_level = threshold * wald_pkg::WINDOW;
      if (window_total[turn] > floor_level) begin
        if (above_run[turn] != wald_pkg::CNT_MAX) above_run[turn] = above_run[turn] + 1'b1;
      end else begin
        above_run[turn] = '0;
      end
      res.ch  = wald_pkg::CHOUT_W'(turn);
      res.hit = (above_run[turn] > run_limit);
      if (res.hit) clear_channel(turn);
      expected_q.push_back(res);
      turn = (turn == wald_pkg::CH_W'(wald_pkg::CHANNELS - 1)) ? '0 : turn + 1'b1;
    endfunction

    function void flag(string msg);
      error_count++;
      if (error_count <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void check_detection(logic [wald_pkg::CHOUT_W-1:0] ch, logic hit);
      detection_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        flag($sformatf("result ch %0d hit %0d with none outstanding", ch, hit));
        return;
      end
      want = expected_q.pop_front();
      if (want.ch !== ch)
        flag($sformatf("channel expected %0d, got %0d", want.ch, ch));
      if (want.hit !== hit)
        flag($sformatf("detected on ch %0d expected %0d, got %0d", want.ch, want.hit, hit));
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  localparam int LONG_HOLD = 200;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            in_valid;
  logic                            in_ready;
  logic [wald_pkg::SAMPLE_W-1:0]   sample;
  logic                            out_valid;
  logic                            out_ready;
  logic [wald_pkg::CHOUT_W-1:0]    channel;
  logic                            detected;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [wald_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [wald_pkg::CFG_DATA_W-1:0] cfg_data;

  level_tracker tracker;
  int           samples_sent = 0;
  bit           source_idles = 1'b0;
  bit           sink_idles   = 1'b0;
  bit           sink_hold_req = 1'b0;

  windowed_average_level_detector_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .channel   (channel),
    .detected  (detected),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watch all three channels at the edge; inputs are noted before results so
  // a same-cycle pass-through would still line up
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) tracker.set_register(cfg_index, cfg_data);
      if (in_valid && in_ready) tracker.take_sample(sample);
      if (out_valid && out_ready) tracker.check_detection(channel, detected);
    end
  end

  // offer one sample request, optionally after a random gap; returns at the
  // edge where it is taken, leaving valid high so back-to-back requests
  // never drop valid in between
  task automatic offer_sample(logic [wald_pkg::SAMPLE_W-1:0] s);
    int gap;
    gap = source_idles ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    samples_sent++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering and wait until every flag has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.results_seen < samples_sent) @(posedge clk);
  endtask

  // both registers are written back to back while the block is idle
  task automatic set_levels(logic [wald_pkg::CFG_DATA_W-1:0] thr_word,
                            logic [wald_pkg::CFG_DATA_W-1:0] run_word);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= wald_pkg::REG_LEVEL_THRESHOLD;
    cfg_data  <= thr_word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= wald_pkg::REG_RUN_LENGTH;
    cfg_data  <= run_word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result side: random back-pressure per result, plus one long hold on
  // request so the block backs up into its input
  initial begin : result_sink
    int wait_cycles;
    out_ready = 1'b0;
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      wait_cycles = sink_idles ? $urandom_range(0, 6) : 0;
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    // extremes and alternating bit patterns under the reset settings
    logic [wald_pkg::SAMPLE_W-1:0] opening [9] = '{12'd0, 12'hFFF, 12'hAAA, 12'h555,
                                                   12'hFFF, 12'hFFF, 12'd1, 12'h800,
                                                   12'hFFE};
    // zero threshold, zero run: any nonzero window fires at once
    logic [wald_pkg::SAMPLE_W-1:0] hair_trigger [7] = '{12'hFFF, 12'hAAA, 12'h555, 12'd0,
                                                        12'd0, 12'd0, 12'd1};
    int unsigned thr;
    int unsigned run;
    int          count;

    tracker   = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    sample    = '0;
    cfg_valid = 1'b0;
    cfg_index = wald_pkg::REG_LEVEL_THRESHOLD;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part, no idling
    foreach (opening[k]) offer_sample(opening[k]);
    set_levels(wald_pkg::CFG_DATA_W'(0), wald_pkg::CFG_DATA_W'(0));
    foreach (hair_trigger[k]) offer_sample(hair_trigger[k]);
    // top threshold with the count limit at maximum: never fires; spare
    // data bits above the run length field are set
    set_levels(wald_pkg::CFG_DATA_W'(4095), wald_pkg::CFG_DATA_W'({4'hA, 8'hFF}));
    for (int k = 0; k < 3; k++) offer_sample(12'hFFF);
    offer_sample(12'd0);

    // full-scale windows one step above the threshold: sum must not wrap
    source_idles = 1'b1;
    sink_idles   = 1'b1;
    run = $urandom_range(0, 3);
    set_levels(wald_pkg::CFG_DATA_W'(4094), wald_pkg::CFG_DATA_W'(run));
    for (int k = 0; k < 165; k++) offer_sample(12'hFFF);

    // mixed settings, mostly sustained levels at or above the threshold
    for (int p = 0; p < 4; p++) begin
      case ($urandom_range(0, 2))
        0:       thr = $urandom_range(0, 4095);
        1:       thr = $urandom_range(0, 300);
        default: thr = $urandom_range(3800, 4095);
      endcase
      run = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 254) : $urandom_range(0, 6);
      source_idles = ($urandom_range(0, 3) != 0);
      sink_idles   = ($urandom_range(0, 3) != 0);
      set_levels(wald_pkg::CFG_DATA_W'(thr),
                 {4'($urandom_range(0, 15)), wald_pkg::RUN_W'(run)});
      count = $urandom_range(8, 16);
      for (int k = 0; k < count; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          offer_sample(wald_pkg::SAMPLE_W'($urandom_range(0, 4095)));
        end else begin
          offer_sample(wald_pkg::SAMPLE_W'($urandom_range(thr, 4095)));
        end
      end
    end

    // saturation: every channel stays above for more than 255 samples with
    // the limit at maximum, then the limit drops by one and each fires next
    // time round; the sink holds off early on while samples keep coming
    source_idles = 1'b0;
    sink_idles   = 1'b1;
    set_levels(wald_pkg::CFG_DATA_W'(0), wald_pkg::CFG_DATA_W'(255));
    sink_hold_req = 1'b1;
    for (int k = 0; k < 771; k++) offer_sample(wald_pkg::SAMPLE_W'($urandom_range(1, 4095)));
    set_levels(wald_pkg::CFG_DATA_W'(0), wald_pkg::CFG_DATA_W'(254));
    for (int k = 0; k < 3; k++) offer_sample(wald_pkg::SAMPLE_W'($urandom_range(1, 4095)));

    settle();
    repeat (4) @(posedge clk);
    if (tracker.error_count == 0 && tracker.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
